// ===== hw/rtl/tbgd_pkg.sv =====
// Package for the two-button gesture detector.
// Holds the hold-mode encoding, gesture codes, field widths and the gesture event struct.
// Used by tbgd_fsm and two_button_gesture_detector_core; depends on nothing.
package tbgd_pkg;

  localparam int THR_W        = 16;
  localparam int GESTURE_W    = 3;
  localparam int COUNT_W_DEF  = 16;
  localparam logic [THR_W-1:0] LONG_PRESS_RST = 16'd800;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_EDGE = 1'b1;

  localparam logic BTN_A = 1'b0;
  localparam logic BTN_B = 1'b1;

  localparam logic [GESTURE_W-1:0] G_SHORT_A = 3'd0;
  localparam logic [GESTURE_W-1:0] G_SHORT_B = 3'd1;
  localparam logic [GESTURE_W-1:0] G_CHORD   = 3'd2;
  localparam logic [GESTURE_W-1:0] G_LONG_A  = 3'd3;
  localparam logic [GESTURE_W-1:0] G_LONG_B  = 3'd4;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'b001,
    MODE_A    = 3'b010,
    MODE_B    = 3'b100
  } mode_t;

  typedef struct packed {
    logic                 valid;
    logic [GESTURE_W-1:0] gesture;
  } gesture_evt_t;

endpackage

// ===== hw/rtl/tbgd_fsm.sv =====
// Hold-mode state machine and saturating tick counter of the gesture detector.
// Consumes one request per step strobe and reports at most one gesture per step.
// Depends on tbgd_pkg.
module tbgd_fsm #(
  parameter int COUNT_WIDTH = tbgd_pkg::COUNT_W_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step,
  input  logic                        operation,
  input  logic                        button,
  input  logic                        pressed,
  input  logic [tbgd_pkg::THR_W-1:0]  threshold,
  output tbgd_pkg::gesture_evt_t      evt
);

  localparam int CMP_W = (COUNT_WIDTH > tbgd_pkg::THR_W) ? COUNT_WIDTH : tbgd_pkg::THR_W;

  tbgd_pkg::mode_t        mode_r, mode_nxt, own;
  logic [COUNT_WIDTH-1:0] cnt_r, cnt_nxt, cnt_inc;
  logic [CMP_W-1:0]       cnt_ext, thr_ext;

  assign own     = (button == tbgd_pkg::BTN_A) ? tbgd_pkg::MODE_A : tbgd_pkg::MODE_B;
  assign cnt_inc = (cnt_r == {COUNT_WIDTH{1'b1}}) ? cnt_r : cnt_r + COUNT_WIDTH'(1);
  assign cnt_ext = CMP_W'(cnt_inc);
  assign thr_ext = CMP_W'(threshold);

  always_comb begin
    mode_nxt    = mode_r;
    cnt_nxt     = cnt_r;
    evt.valid   = 1'b0;
    evt.gesture = tbgd_pkg::G_SHORT_A;
    if (step) begin
      if (operation == tbgd_pkg::OP_TICK) begin
        if (mode_r != tbgd_pkg::MODE_IDLE) begin
          cnt_nxt = cnt_inc;
          if (cnt_ext >= thr_ext) begin
            mode_nxt    = tbgd_pkg::MODE_IDLE;
            evt.valid   = 1'b1;
            evt.gesture = (mode_r == tbgd_pkg::MODE_A) ? tbgd_pkg::G_LONG_A
                                                       : tbgd_pkg::G_LONG_B;
          end
        end
      end else if (pressed) begin
        if (mode_r == tbgd_pkg::MODE_IDLE) begin
          mode_nxt = own;
          cnt_nxt  = '0;
        end else if (mode_r != own) begin
          mode_nxt    = tbgd_pkg::MODE_IDLE;
          evt.valid   = 1'b1;
          evt.gesture = tbgd_pkg::G_CHORD;
        end
      end else if (mode_r == own) begin
        mode_nxt    = tbgd_pkg::MODE_IDLE;
        evt.valid   = 1'b1;
        evt.gesture = (own == tbgd_pkg::MODE_A) ? tbgd_pkg::G_SHORT_A
                                                : tbgd_pkg::G_SHORT_B;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= tbgd_pkg::MODE_IDLE;
      cnt_r  <= '0;
    end else begin
      mode_r <= mode_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Every gesture ends the hold.
  a_evt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    evt.valid |=> mode_r == tbgd_pkg::MODE_IDLE)
    else $error("gesture did not return to idle");

  // A press from idle restarts the elapsed count.
  a_press_clr: assert property (@(posedge clk) disable iff (!rst_n)
    step && operation == tbgd_pkg::OP_EDGE && pressed && mode_r == tbgd_pkg::MODE_IDLE
    |=> cnt_r == '0 && mode_r != tbgd_pkg::MODE_IDLE)
    else $error("press from idle did not start a hold");

  // Without a request neither the mode nor the count moves.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(cnt_r) && $stable(mode_r))
    else $error("state changed without a request");

  // Long-press gestures come only from ticks.
  a_long_tick: assert property (@(posedge clk) disable iff (!rst_n)
    evt.valid && (evt.gesture == tbgd_pkg::G_LONG_A || evt.gesture == tbgd_pkg::G_LONG_B)
    |-> operation == tbgd_pkg::OP_TICK)
    else $error("long press from an edge");

endmodule

// ===== hw/rtl/two_button_gesture_detector_core.sv =====
// A request is held in the input register once accepted; when it advances, its gesture,
// if any, enters the result register. It cannot advance while a result waits with
// out_ready low; throughput is one request per cycle while out_ready is high.
// The hold-mode state and tick counter are updated in the single step between the two
// registers. Reset (rst_n, synchronous, active low) returns to idle, clears the counter,
// empties both registers and sets the long-press threshold to 800 ticks.
module two_button_gesture_detector_core #(
  parameter int COUNT_WIDTH = tbgd_pkg::COUNT_W_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_operation,
  input  logic                            in_button,
  input  logic                            in_pressed,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [tbgd_pkg::GESTURE_W-1:0]  out_gesture,
  input  logic                            cfg_we,
  input  logic [tbgd_pkg::THR_W-1:0]      cfg_wdata
);

  logic                            req_v_r, req_v_nxt;
  logic                            op_r, btn_r, prs_r;
  logic                            out_v_r, out_v_nxt;
  logic [tbgd_pkg::GESTURE_W-1:0]  gest_r;
  logic [tbgd_pkg::THR_W-1:0]      thr_r;
  logic                            adv, acc;
  tbgd_pkg::gesture_evt_t          evt;

  assign adv      = req_v_r && (!out_v_r || out_ready);
  assign in_ready = !req_v_r || adv;
  assign acc      = in_valid && in_ready;

  assign req_v_nxt = acc ? 1'b1 : (adv ? 1'b0 : req_v_r);

  always_comb begin
    out_v_nxt = out_v_r;
    if (adv) begin
      out_v_nxt = evt.valid;
    end else if (out_ready) begin
      out_v_nxt = 1'b0;
    end
  end

  tbgd_fsm #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_fsm (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (adv),
    .operation (op_r),
    .button    (btn_r),
    .pressed   (prs_r),
    .threshold (thr_r),
    .evt       (evt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_v_r <= 1'b0;
      out_v_r <= 1'b0;
      thr_r   <= tbgd_pkg::LONG_PRESS_RST;
    end else begin
      req_v_r <= req_v_nxt;
      out_v_r <= out_v_nxt;
      if (cfg_we) begin
        thr_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      op_r  <= in_operation;
      btn_r <= in_button;
      prs_r <= in_pressed;
    end
    if (adv && evt.valid) begin
      gest_r <= evt.gesture;
    end
  end

  assign out_valid   = out_v_r;
  assign out_gesture = gest_r;

  // A waiting result is never overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_ready |=> out_v_r && $stable(gest_r))
    else $error("pending result lost");

  // A buffered request that cannot move blocks new requests.
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    req_v_r && out_v_r && !out_ready |-> !in_ready)
    else $error("request accepted over a stalled one");

  // Output codes stay within the defined gestures.
  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> gest_r <= tbgd_pkg::G_LONG_B)
    else $error("undefined gesture code");

endmodule

// ===== test/two_button_gesture_detector_core_tb.sv =====
// Testbench for two_button_gesture_detector_core: drives taps, chords, long holds and ticks,
// predicts each gesture in lockstep and checks the results in order under random stalls.
// Depends on tbgd_pkg and the detector RTL; needs no files or arguments.
module two_button_gesture_detector_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic                           clk;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_ready;
  logic                           in_operation;
  logic                           in_button;
  logic                           in_pressed;
  logic                           out_valid;
  logic                           out_ready;
  logic [tbgd_pkg::GESTURE_W-1:0] out_gesture;
  logic                           cfg_we;
  logic [tbgd_pkg::THR_W-1:0]     cfg_wdata;

  tbgd_pkg::mode_t                  held_mode;
  logic [tbgd_pkg::COUNT_W_DEF-1:0] held_ticks;
  logic [tbgd_pkg::THR_W-1:0]       press_threshold;
  logic [tbgd_pkg::GESTURE_W-1:0]   expected_gestures[$];

  int send_idle_pct;
  int recv_idle_pct;
  int recv_holdoff_req;
  int fail_count;
  int gestures_checked;
  int requests_sent;
  int active_requests;

  two_button_gesture_detector_core dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .in_button    (in_button),
    .in_pressed   (in_pressed),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_gesture  (out_gesture),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #(20_000_000);
    $display("TB_ERROR");
    $finish;
  end

  function automatic bit apply_request(logic op, logic btn, logic lvl);
    tbgd_pkg::mode_t own;
    if (op == tbgd_pkg::OP_TICK) begin
      if (held_mode == tbgd_pkg::MODE_IDLE) return 1'b0;
      if (held_ticks != '1) held_ticks++;
      if (held_ticks >= press_threshold) begin
        expected_gestures.push_back(held_mode == tbgd_pkg::MODE_A ? tbgd_pkg::G_LONG_A
                                                                  : tbgd_pkg::G_LONG_B);
        held_mode = tbgd_pkg::MODE_IDLE;
      end
      return 1'b1;
    end
    own = (btn == tbgd_pkg::BTN_A) ? tbgd_pkg::MODE_A : tbgd_pkg::MODE_B;
    if (lvl) begin
      if (held_mode == tbgd_pkg::MODE_IDLE) begin
        held_mode = own;
        held_ticks = '0;
        return 1'b1;
      end
      if (held_mode != own) begin
        expected_gestures.push_back(tbgd_pkg::G_CHORD);
        held_mode = tbgd_pkg::MODE_IDLE;
        return 1'b1;
      end
      return 1'b0;
    end
    if (held_mode == own) begin
      expected_gestures.push_back(own == tbgd_pkg::MODE_A ? tbgd_pkg::G_SHORT_A
                                                          : tbgd_pkg::G_SHORT_B);
      held_mode = tbgd_pkg::MODE_IDLE;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic send_request(input logic op, input logic btn, input logic lvl);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_button    <= btn;
    in_pressed   <= lvl;
    do @(posedge clk); while (!in_ready);
    if (apply_request(op, btn, lvl)) active_requests++;
    requests_sent++;
  endtask

  task automatic send_ticks(input int count);
    repeat (count) send_request(tbgd_pkg::OP_TICK, 1'($urandom_range(0, 1)),
                                1'($urandom_range(0, 1)));
  endtask

  task automatic drain_pipeline();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_gestures.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_long_press(input logic [tbgd_pkg::THR_W-1:0] value);
    drain_pipeline();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    press_threshold = value;
  endtask

  initial begin
    out_ready = 1'b0;
    forever begin
      int holdoff_left;
      @(negedge clk);
      if (recv_holdoff_req > 0) begin
        holdoff_left = recv_holdoff_req;
        recv_holdoff_req = 0;
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_gestures.size() == 0) begin
        $error("gesture: expected none, actual %0d", out_gesture);
        fail_count++;
      end else begin
        logic [tbgd_pkg::GESTURE_W-1:0] exp_gesture;
        exp_gesture = expected_gestures.pop_front();
        gestures_checked++;
        if (out_gesture !== exp_gesture) begin
          $error("gesture: expected %0d, actual %0d", exp_gesture, out_gesture);
          fail_count++;
        end
      end
    end
  end

  task automatic test_reset_threshold();
    send_request(tbgd_pkg::OP_EDGE, tbgd_pkg::BTN_A, 1'b1);
    send_ticks(800);
  endtask

  task automatic test_edge_cases();
    set_long_press(16'd3);
    send_ticks(1);
    send_request(tbgd_pkg::OP_EDGE, tbgd_pkg::BTN_A, 1'b0);
    send_request(tbgd_pkg::OP_EDGE, tbgd_pkg::BTN_B, 1'b0);
    send_request(tbgd_pkg::OP_EDGE, tbgd_pkg::BTN_A, 1'b1);
    send_request(tbgd_pkg::OP_EDGE, tbgd_pkg::BTN_A, 1'b1);
    send_request(tbgd_pkg::OP_EDGE, tbgd_pkg::BTN_B, 1'b0);
    send_ticks(1);
    send_request(tbgd_pkg::OP_EDGE, tbgd_pkg::BTN_A, 1'b0);
    send_request(tbgd_pkg::OP_EDGE, tbgd_pkg::BTN_B, 1'b1);
    send_request(tbgd_pkg::OP_EDGE, tbgd_pkg::BTN_B, 1'b0);
    send_request(tbgd_pkg::OP_EDGE, tbgd_pkg::BTN_A, 1'b1);
    send_request(tbgd_pkg::OP_EDGE, tbgd_pkg::BTN_B, 1'b1);
    send_request(tbgd_pkg::OP_EDGE, tbgd_pkg::BTN_B, 1'b1);
    send_request(tbgd_pkg::OP_EDGE, tbgd_pkg::BTN_A, 1'b1);
    send_request(tbgd_pkg::OP_EDGE, tbgd_pkg::BTN_B, 1'b1);
    send_ticks(3);
    send_request(tbgd_pkg::OP_EDGE, tbgd_pkg::BTN_B, 1'b0);
    send_request(tbgd_pkg::OP_EDGE, tbgd_pkg::BTN_A, 1'b1);
    send_ticks(3);
  endtask

  task automatic test_small_thresholds();
    set_long_press(16'd0);
    send_request(tbgd_pkg::OP_EDGE, tbgd_pkg::BTN_A, 1'b1);
    send_ticks(1);
    set_long_press(16'd1);
    send_request(tbgd_pkg::OP_EDGE, tbgd_pkg::BTN_B, 1'b1);
    send_ticks(1);
  endtask

  task automatic test_max_threshold();
    set_long_press(16'hFFFF);
    send_request(tbgd_pkg::OP_EDGE, tbgd_pkg::BTN_A, 1'b1);
    send_ticks(20);
    send_request(tbgd_pkg::OP_EDGE, tbgd_pkg::BTN_A, 1'b0);
    send_request(tbgd_pkg::OP_EDGE, tbgd_pkg::BTN_B, 1'b1);
    send_ticks(20);
    send_request(tbgd_pkg::OP_EDGE, tbgd_pkg::BTN_A, 1'b1);
  endtask

  task automatic test_output_holdoff();
    set_long_press(16'd2);
    recv_holdoff_req = 80;
    repeat (20) begin
      logic btn;
      btn = 1'($urandom_range(0, 1));
      send_request(tbgd_pkg::OP_EDGE, btn, 1'b1);
      send_request(tbgd_pkg::OP_EDGE, btn, 1'b0);
    end
  endtask

  task automatic test_random_gestures(input logic [tbgd_pkg::THR_W-1:0] threshold,
                                      input int target);
    int start;
    int steps;
    int pick;
    logic own_btn;
    set_long_press(threshold);
    start = active_requests;
    while (active_requests - start < target) begin
      if ($urandom_range(0, 99) < 20) begin
        send_request(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)));
      end else begin
        send_request(tbgd_pkg::OP_EDGE, 1'($urandom_range(0, 1)), 1'b1);
        steps = 0;
        while (held_mode != tbgd_pkg::MODE_IDLE && steps < int'(threshold) + 12) begin
          own_btn = (held_mode == tbgd_pkg::MODE_B) ? tbgd_pkg::BTN_B : tbgd_pkg::BTN_A;
          pick = $urandom_range(0, 99);
          if (pick < 70) send_ticks(1);
          else if (pick < 80) send_request(tbgd_pkg::OP_EDGE, own_btn, 1'b0);
          else if (pick < 88) send_request(tbgd_pkg::OP_EDGE, ~own_btn, 1'b1);
          else if (pick < 94) send_request(tbgd_pkg::OP_EDGE, own_btn, 1'b1);
          else send_request(tbgd_pkg::OP_EDGE, ~own_btn, 1'b0);
          steps++;
        end
        if (held_mode != tbgd_pkg::MODE_IDLE)
          send_request(tbgd_pkg::OP_EDGE,
                       (held_mode == tbgd_pkg::MODE_B) ? tbgd_pkg::BTN_B : tbgd_pkg::BTN_A,
                       1'b0);
      end
    end
  endtask

  initial begin
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_operation     = tbgd_pkg::OP_TICK;
    in_button        = tbgd_pkg::BTN_A;
    in_pressed       = 1'b0;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    send_idle_pct    = 16;
    recv_idle_pct    = 46;
    recv_holdoff_req = 0;
    fail_count       = 0;
    gestures_checked = 0;
    requests_sent    = 0;
    active_requests  = 0;
    held_mode        = tbgd_pkg::MODE_IDLE;
    held_ticks       = '0;
    press_threshold  = tbgd_pkg::LONG_PRESS_RST;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    test_reset_threshold();
    test_edge_cases();
    test_small_thresholds();
    test_output_holdoff();
    test_random_gestures(16'd5, 80);
    test_random_gestures(16'd0, 80);

    send_idle_pct = 46;
    recv_idle_pct = 16;
    test_random_gestures(16'($urandom_range(6, 20)), 80);
    test_random_gestures(16'd1, 80);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_max_threshold();
    test_random_gestures(16'($urandom_range(2, 40)), 80);
    test_random_gestures(16'($urandom_range(2, 9)), 80);

    drain_pipeline();
    $display("Checked %0d gestures from %0d requests, thresholds from 0 to 65535,",
             gestures_checked, requests_sent);
    $display("with random stalls on both sides and a long output hold-off.");
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
